// ----- src/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Request codes, register indexes, payload structs and the fixed-point
// constants for the centimeter conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Default number of entries in the sliding median window.
  localparam int MEDIAN_TAPS_DEF = 5;

  // Field widths.
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int REG_W    = 16;
  localparam int DIST_W   = 11;
  localparam int REQ_W    = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PING   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;

  // Configuration register indexes. Indexes past the last register are ignored.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ECHO_US       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEALTH_TIMEOUT_MS = 2'd1;

  // Register reset values.
  localparam logic [REG_W-1:0] MAX_ECHO_US_RST       = 16'd50000;
  localparam logic [REG_W-1:0] HEALTH_TIMEOUT_MS_RST = 16'd150;

  // Distance: (sample * 167 + 5000) / 10000. The divide by 10000 is a
  // multiply by ceil(2^37 / 10000) and a shift, exact for inputs below 2^24.
  localparam int PROD_W      = 24;
  localparam int DIST_MUL    = 167;
  localparam int DIST_BIAS   = 5000;
  localparam int RECIP_M     = 13743896;
  localparam int RECIP_SHIFT = 37;

  // One input word.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic              echo_level;
    logic [TIME_W-1:0] capture_us;
    logic [TIME_W-1:0] now_ms;
  } uer_in_t;

  // One result word.
  typedef struct packed {
    logic              trig_pulse;
    logic              sample_accepted;
    logic [DIST_W-1:0] range_cm;
    logic              healthy;
  } uer_out_t;

  // Status handed from the event stage to the distance stages.
  typedef struct packed {
    logic                valid;
    logic                trig;
    logic                accepted;
    logic                healthy;
    logic [SAMPLE_W-1:0] sample;
  } uer_stat_t;

endpackage

`default_nettype wire

// ----- src/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: time-of-flight ranger with sliding median filter
// Echo edge, ping and status events in; one result word per event out.
// ----------------------------------------------------------------------------
// The ranger takes one event word per clock unless the result side stalls,
// and returns exactly one result word per event, in order. An accepted word
// reaches the result port through the stages in order; the
// pipeline is an input register, an event stage that updates the timestamps,
// the median window and the health timer, a scale stage, and a divide stage
// that feeds the result register. The whole pipeline moves together, so a
// stalled result holds every stage and req_ready falls in the same cycle.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata
// and should only change while no event is in flight.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire uer_pkg::uer_in_t                req_data,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output uer_pkg::uer_out_t                    rsp_data,
  input  wire logic                            cfg_we,
  input  wire logic [uer_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [uer_pkg::REG_W-1:0]       cfg_wdata
);
  import uer_pkg::*;

  logic      adv;
  uer_stat_t stat;

  // The pipeline advances whenever the result register is free or drained.
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  uer_core #(
    .MEDIAN_TAPS(MEDIAN_TAPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req_data  (req_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .stat      (stat)
  );

  uer_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  // An unhealthy report never carries a distance.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.healthy |-> rsp_data.range_cm == '0)
    else $error("unhealthy result with nonzero distance");

  // A freshly accepted sample comes only from a ping and is always healthy.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.sample_accepted |-> rsp_data.trig_pulse && rsp_data.healthy)
    else $error("accepted sample without ping or health");

  // The rounded distance of a 16-bit sample stays within range.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.range_cm <= 11'd1094)
    else $error("distance out of range");

endmodule

`default_nettype wire

// ----- src/uer_median.sv -----
// ----------------------------------------------------------------------------
// uer_median: median of the sliding window
// Ranks every entry against all others in parallel, breaking ties by
// position, and selects the entry whose rank is the middle one.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_median #(
  parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
  input  wire logic [MEDIAN_TAPS-1:0][uer_pkg::SAMPLE_W-1:0] window,
  output logic [uer_pkg::SAMPLE_W-1:0]                       median
);
  import uer_pkg::*;

  localparam int CNT_W = $clog2(MEDIAN_TAPS);
  localparam logic [CNT_W-1:0] MID = CNT_W'(MEDIAN_TAPS / 2);

  logic [MEDIAN_TAPS-1:0][CNT_W-1:0] rank;

  // Rank of each entry: count of entries that sort ahead of it.
  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i) begin
          if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
    end
  end

  // Exactly one entry holds the middle rank.
  always_comb begin
    median = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (rank[i] == MID) begin
        median = window[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/uer_core.sv -----
// ----------------------------------------------------------------------------
// uer_core: input register, ranger state and event processing
// Holds the timestamps, the median window and the health timer, applies
// one event per cycle while adv is high and registers the resulting status word.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_core #(
  parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            adv,
  input  wire logic                            req_valid,
  input  wire uer_pkg::uer_in_t                req_data,
  input  wire logic                            cfg_we,
  input  wire logic [uer_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [uer_pkg::REG_W-1:0]       cfg_wdata,
  output uer_pkg::uer_stat_t                   stat
);
  import uer_pkg::*;

  localparam int PTR_W = $clog2(MEDIAN_TAPS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MEDIAN_TAPS - 1);

  // Configuration registers.
  logic [REG_W-1:0] max_echo_us;
  logic [REG_W-1:0] health_timeout_ms;

  // Input register.
  logic    in_vld;
  uer_in_t in_q;

  // Ranger state.
  logic [TIME_W-1:0]                       echo_start_us;
  logic [TIME_W-1:0]                       last_capture_us;
  logic [MEDIAN_TAPS-1:0][SAMPLE_W-1:0]    median_window;
  logic [PTR_W-1:0]                        window_pointer;
  logic [SAMPLE_W-1:0]                     filtered_sample;
  logic [TIME_W-1:0]                       last_valid_ms;

  // Event decode and datapath.
  logic                                    is_edge;
  logic                                    is_ping;
  logic                                    is_status;
  logic [TIME_W-1:0]                       diff;
  logic                                    accept;
  logic [MEDIAN_TAPS-1:0][SAMPLE_W-1:0]    window_next;
  logic [SAMPLE_W-1:0]                     median;
  logic [TIME_W-1:0]                       elapsed;
  logic                                    healthy;
  logic [SAMPLE_W-1:0]                     sample_next;
  uer_stat_t                               stat_next;

  assign is_edge   = in_vld && (in_q.req_type == REQ_EDGE);
  assign is_ping   = in_vld && (in_q.req_type == REQ_PING);
  assign is_status = in_vld && (in_q.req_type == REQ_STATUS);

  // Echo duration, read as signed: accepted when strictly inside (0, limit).
  assign diff   = last_capture_us - echo_start_us;
  assign accept = is_ping && (diff != '0) && !diff[TIME_W-1]
                  && (diff < {{(TIME_W-REG_W){1'b0}}, max_echo_us});

  // Window with the new duration written at the pointer.
  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (window_pointer == PTR_W'(i)) begin
        window_next[i] = diff[SAMPLE_W-1:0];
      end else begin
        window_next[i] = median_window[i];
      end
    end
  end

  uer_median #(
    .MEDIAN_TAPS(MEDIAN_TAPS)
  ) u_median (
    .window(window_next),
    .median(median)
  );

  // Health after the update: a fresh sample always counts as healthy.
  assign elapsed = in_q.now_ms - last_valid_ms;
  assign healthy = accept || (elapsed <= {{(TIME_W-REG_W){1'b0}}, health_timeout_ms});

  always_comb begin
    sample_next = accept ? median : filtered_sample;
    stat_next.valid    = in_vld;
    stat_next.trig     = is_ping;
    stat_next.accepted = accept;
    stat_next.healthy  = (is_ping || is_status) && healthy;
    stat_next.sample   = stat_next.healthy ? sample_next : '0;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_echo_us       <= MAX_ECHO_US_RST;
      health_timeout_ms <= HEALTH_TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_ECHO_US:       max_echo_us       <= cfg_wdata;
        REG_HEALTH_TIMEOUT_MS: health_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv) begin
      in_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_q <= req_data;
    end
  end

  // State updates for edge and ping events.
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_start_us   <= '0;
      last_capture_us <= '0;
      median_window   <= '0;
      window_pointer  <= '0;
      filtered_sample <= '0;
      last_valid_ms   <= '0;
    end else if (adv) begin
      if (is_edge) begin
        if (in_q.echo_level) begin
          echo_start_us <= in_q.capture_us;
        end
        last_capture_us <= in_q.capture_us;
      end
      if (accept) begin
        median_window   <= window_next;
        window_pointer  <= (window_pointer == PTR_LAST) ? '0 : window_pointer + 1'b1;
        filtered_sample <= median;
        last_valid_ms   <= in_q.now_ms;
      end
    end
  end

  // Status register. Only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.valid <= 1'b0;
    end else if (adv) begin
      stat.valid <= stat_next.valid;
    end
    if (adv) begin
      stat.trig     <= stat_next.trig;
      stat.accepted <= stat_next.accepted;
      stat.healthy  <= stat_next.healthy;
      stat.sample   <= stat_next.sample;
    end
  end

endmodule

`default_nettype wire

// ----- src/uer_dist.sv -----
// ----------------------------------------------------------------------------
// uer_dist: centimeter conversion and result register
// Scales the sample by 167 with rounding bias in one stage, divides by
// 10000 through a reciprocal multiply in the next, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dist (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire uer_pkg::uer_stat_t stat,
  output logic                    rsp_valid,
  output uer_pkg::uer_out_t       rsp_data
);
  import uer_pkg::*;

  localparam logic [PROD_W-1:0] MUL_K  = PROD_W'(DIST_MUL);
  localparam logic [PROD_W-1:0] BIAS_K = PROD_W'(DIST_BIAS);
  localparam logic [PROD_W-1:0] RECIP  = PROD_W'(RECIP_M);

  // Scale stage.
  logic              sc_vld;
  logic              sc_trig;
  logic              sc_acc;
  logic              sc_healthy;
  logic [PROD_W-1:0] sc_x;
  logic [PROD_W-1:0] x_next;

  // Divide stage.
  logic [2*PROD_W-1:0] quot_prod;

  assign x_next    = {{(PROD_W-SAMPLE_W){1'b0}}, stat.sample} * MUL_K + BIAS_K;
  assign quot_prod = {{PROD_W{1'b0}}, sc_x} * {{PROD_W{1'b0}}, RECIP};

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      sc_vld    <= stat.valid;
      rsp_valid <= sc_vld;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      sc_trig                  <= stat.trig;
      sc_acc                   <= stat.accepted;
      sc_healthy               <= stat.healthy;
      sc_x                     <= x_next;
      rsp_data.trig_pulse      <= sc_trig;
      rsp_data.sample_accepted <= sc_acc;
      rsp_data.healthy         <= sc_healthy;
      rsp_data.range_cm        <= quot_prod[RECIP_SHIFT +: DIST_W];
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger: self-checking bench for the echo ranger
// Drives edge, ping, status and spare-code words through the request port
// under random bursts and result-side stalls. A local model of the ranger
// predicts each result word, and every received word is compared field by
// field, in order. Both limit registers are swept through several settings,
// the extremes and zero among them, with the pipeline drained before each
// write.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int TAPS = MEDIAN_TAPS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 270;

  // The fourth request code is unused; the ranger must ignore it.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // Receiver stall patterns.
  localparam int STALL_NONE = 0;
  localparam int STALL_RANDOM = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  uer_in_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  uer_out_t rsp_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  // Model state of the ranger and its registers.
  logic [TIME_W-1:0] edge_start_us;
  logic [TIME_W-1:0] edge_last_us;
  logic [SAMPLE_W-1:0] win [TAPS];
  int win_ptr;
  logic [SAMPLE_W-1:0] median_us;
  logic [TIME_W-1:0] valid_ms;
  logic [REG_W-1:0] lim_echo_us;
  logic [REG_W-1:0] lim_health_ms;

  uer_out_t pending_reports [$];
  uer_out_t want;
  int n_bad = 0;
  int n_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  logic [TIME_W-1:0] ms_clock;
  int cycle_count = 0;

  int stall_mode = STALL_NONE;
  logic [6:0] stall_age = '0;
  int hold_cnt = 0;

  always #2 clk = ~clk;

  ultrasonic_echo_ranger u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Health and distance as seen at time now; distance is zero when unhealthy.
  function automatic uer_out_t with_health(input uer_out_t r, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    logic [31:0] scaled;
    elapsed = now - valid_ms;
    if (elapsed <= {16'd0, lim_health_ms}) begin
      // Rounded sample * 0.0167, ties upward.
      scaled = ({16'd0, median_us} * 32'd167 + 32'd5000) / 32'd10000;
      r.range_cm = scaled[DIST_W-1:0];
      r.healthy = 1'b1;
    end
    return r;
  endfunction

  // Advances the model by one event word and returns the expected result.
  function automatic uer_out_t ranger_predict(input uer_in_t w);
    uer_out_t r;
    logic [TIME_W-1:0] span;
    logic [SAMPLE_W-1:0] srt [TAPS];
    logic [SAMPLE_W-1:0] tmp;
    r = '0;
    case (w.req_type)
      REQ_EDGE: begin
        if (w.echo_level) begin
          edge_start_us = w.capture_us;
        end
        edge_last_us = w.capture_us;
      end
      REQ_PING: begin
        span = edge_last_us - edge_start_us;
        // Accept only a positive duration below the limit.
        if (span != 0 && !span[31] && span < {16'd0, lim_echo_us}) begin
          win[win_ptr] = span[SAMPLE_W-1:0];
          win_ptr = (win_ptr == TAPS - 1) ? 0 : win_ptr + 1;
          srt = win;
          for (int i = 0; i < TAPS - 1; i++) begin
            for (int j = 0; j < TAPS - 1 - i; j++) begin
              if (srt[j] > srt[j+1]) begin
                tmp = srt[j];
                srt[j] = srt[j+1];
                srt[j+1] = tmp;
              end
            end
          end
          median_us = srt[TAPS/2];
          valid_ms = w.now_ms;
          r.sample_accepted = 1'b1;
        end
        r.trig_pulse = 1'b1;
        r = with_health(r, w.now_ms);
      end
      REQ_STATUS: begin
        r = with_health(r, w.now_ms);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sends one event word, with random gaps between bursts when enabled.
  task automatic send_event(input logic [REQ_W-1:0] kind, input logic lvl,
                            input logic [TIME_W-1:0] cap, input logic [TIME_W-1:0] now);
    uer_in_t w;
    w.req_type = kind;
    w.echo_level = lvl;
    w.capture_us = cap;
    w.now_ms = now;
    if (gaps_on && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    req_valid <= 1'b1;
    req_data <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
    pending_reports.push_back(ranger_predict(w));
  endtask

  // Holds the sender until every outstanding word has come back.
  task automatic settle_pipeline();
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes both limit registers while the pipeline is empty.
  task automatic apply_settings(input logic [REG_W-1:0] echo_lim, input logic [REG_W-1:0] tmo);
    settle_pipeline();
    cfg_we <= 1'b1;
    cfg_addr <= REG_MAX_ECHO_US;
    cfg_wdata <= echo_lim;
    @(posedge clk);
    lim_echo_us = echo_lim;
    cfg_addr <= REG_HEALTH_TIMEOUT_MS;
    cfg_wdata <= tmo;
    @(posedge clk);
    lim_health_ms = tmo;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Captures, wrapped timestamps, acceptance bounds and health boundaries
  // under the reset values of the registers.
  task automatic test_echo_capture();
    send_event(REQ_STATUS, 1'b0, '0, '0);
    send_event(REQ_SPARE, 1'b1, '1, '1);
    // Rising edge just before the timer wraps, falling edge after it.
    send_event(REQ_EDGE, 1'b1, 32'hFFFF_FFF0, '0);
    send_event(REQ_EDGE, 1'b0, 32'h0000_2000, '0);
    send_event(REQ_PING, 1'b0, '0, 32'hFFFF_FFFF);
    // Exactly at the timeout, then one past it, across the ms wrap.
    send_event(REQ_STATUS, 1'b0, '0, 32'h0000_0095);
    send_event(REQ_STATUS, 1'b0, '0, 32'h0000_0096);
    // Repeated pings pull the median off zero.
    send_event(REQ_PING, 1'b1, '0, '0);
    send_event(REQ_PING, 1'b0, '0, '0);
    // Zero duration, then a falling edge before the rising one.
    send_event(REQ_EDGE, 1'b1, 32'd100, '0);
    send_event(REQ_PING, 1'b0, '0, 32'd10);
    send_event(REQ_EDGE, 1'b0, 32'd50, '0);
    send_event(REQ_PING, 1'b0, '0, 32'd20);
    // One below the limit, then exactly at it.
    send_event(REQ_EDGE, 1'b0, 32'd100 + 32'd49999, '0);
    send_event(REQ_PING, 1'b0, '0, 32'd30);
    send_event(REQ_EDGE, 1'b0, 32'd100 + 32'd50000, '0);
    send_event(REQ_PING, 1'b0, '0, 32'd40);
  endtask

  // Largest duration and distance, zero timeout and zero echo limit.
  task automatic test_register_extremes();
    apply_settings(16'd65535, 16'd0);
    send_event(REQ_EDGE, 1'b0, 32'd100 + 32'd65534, '0);
    repeat (3) send_event(REQ_PING, 1'b0, '0, 32'd1000);
    send_event(REQ_STATUS, 1'b0, '0, 32'd1001);
    apply_settings(16'd0, 16'd65535);
    send_event(REQ_PING, 1'b0, '0, 32'd2000);
    send_event(REQ_STATUS, 1'b0, '0, valid_ms + 32'd65535);
    send_event(REQ_STATUS, 1'b0, '0, valid_ms + 32'd65536);
  endtask

  // Mostly complete measure cycles with random content, plus status
  // queries around the timeout and fully random words.
  task automatic random_traffic(input int n_items);
    int stop_at;
    int pick;
    int r;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] now;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        base = $urandom;
        r = $urandom_range(0, 9);
        if (r < 7) begin
          dur = $urandom_range(1, (lim_echo_us > 1) ? lim_echo_us - 1 : 1);
        end else if (r == 7) begin
          dur = lim_echo_us + $urandom_range(0, 2);
        end else if (r == 8) begin
          dur = '0;
        end else begin
          dur = $urandom;
        end
        send_event(REQ_EDGE, 1'b1, base, $urandom);
        if ($urandom_range(0, 5) == 0) begin
          send_event(REQ_EDGE, 1'b0, $urandom, $urandom);
        end
        send_event(REQ_EDGE, 1'b0, base + dur, $urandom);
        ms_clock = ms_clock + $urandom_range(0, 60);
        send_event(REQ_PING, 1'($urandom_range(0, 1)), $urandom, ms_clock);
      end else if (pick < 88) begin
        r = $urandom_range(0, 3);
        if (r == 0) begin
          now = valid_ms + lim_health_ms;
        end else if (r == 1) begin
          now = valid_ms + lim_health_ms + 1;
        end else begin
          now = valid_ms + $urandom_range(0, lim_health_ms * 2 + 2);
        end
        send_event(REQ_STATUS, 1'($urandom_range(0, 1)), $urandom, now);
      end else begin
        send_event(REQ_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, $urandom);
      end
    end
  endtask

  // Several register settings, with and without sender gaps.
  task automatic test_random_ranging();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(16'd1, 16'd1);
        1: apply_settings(16'd65535, 16'd65535);
        2: apply_settings(16'd1200, 16'd20);
        3: apply_settings(MAX_ECHO_US_RST, HEALTH_TIMEOUT_MS_RST);
        4: apply_settings(REG_W'($urandom_range(1, 65535)), REG_W'($urandom_range(1, 65535)));
        default: apply_settings(16'd40000, 16'd0);
      endcase
      gaps_on = (p != 1 && p != 4);
      random_traffic(ITEMS_PER_PHASE);
    end
  endtask

  // Result-side stalls: a new pattern is drawn each time stall_age wraps.
  always @(posedge clk) begin
    stall_age <= stall_age + 1'b1;
    if (stall_age == '0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      STALL_NONE: begin
        rsp_ready <= 1'b1;
      end
      STALL_RANDOM: begin
        rsp_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        // Long stalls between stretches of ready.
        if (hold_cnt != 0) begin
          rsp_ready <= 1'b0;
          hold_cnt <= hold_cnt - 1;
        end else begin
          rsp_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) begin
            hold_cnt <= $urandom_range(1, 12);
          end
        end
      end
    endcase
  end

  // Compares each received word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_reports.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("result word with nothing expected: trig=%0d acc=%0d dist=%0d ok=%0d",
                   rsp_data.trig_pulse, rsp_data.sample_accepted, rsp_data.range_cm,
                   rsp_data.healthy);
        end
      end else begin
        want = pending_reports.pop_front();
        if (rsp_data.trig_pulse !== want.trig_pulse
            || rsp_data.sample_accepted !== want.sample_accepted
            || rsp_data.range_cm !== want.range_cm
            || rsp_data.healthy !== want.healthy) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: expected trig=%0d acc=%0d dist=%0d ok=%0d,",
                     want.trig_pulse, want.sample_accepted, want.range_cm, want.healthy,
                     " got trig=%0d acc=%0d dist=%0d ok=%0d",
                     rsp_data.trig_pulse, rsp_data.sample_accepted, rsp_data.range_cm,
                     rsp_data.healthy);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    // Model state after reset.
    edge_start_us = '0;
    edge_last_us = '0;
    for (int i = 0; i < TAPS; i++) begin
      win[i] = '0;
    end
    win_ptr = 0;
    median_us = '0;
    valid_ms = '0;
    lim_echo_us = MAX_ECHO_US_RST;
    lim_health_ms = HEALTH_TIMEOUT_MS_RST;
    ms_clock = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_echo_capture();
    test_register_extremes();
    test_random_ranging();
    settle_pipeline();

    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
